### rtl/mcit_pkg.sv
// Package with the shared types and constants of the interval timer bank.
`default_nettype none
package mcit_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int TIDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ARM    = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_PERIOD = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_ADDEXP = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_OPREAD,
        ST_OPEVAL
    } state_t;

    typedef struct packed {
        logic        run;
        logic [31:0] rem;
        logic [31:0] per;
        logic [31:0] cnt;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rmd;
    } div_rsp_t;

endpackage
`default_nettype wire

### rtl/mcit_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module mcit_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mcit_pkg::div_req_t req,
    output mcit_pkg::div_rsp_t     rsp
);

    logic [31:0]               r_reg, r_next;
    logic [31:0]               q_reg, q_next;
    logic [31:0]               d_reg, d_next;
    logic [mcit_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [32:0]               r_sh;
    logic [32:0]               diff;

    always_comb
    begin
        r_sh = {r_reg, q_reg[31]};
        diff = r_sh - {1'b0, d_reg};
        r_next = r_reg;
        q_next = q_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            r_next = '0;
            q_next = req.dividend;
            d_next = req.divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                r_next = diff[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[31:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mcit_pkg::DCNT_W'(mcit_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rmd = r_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without work");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
`endif

endmodule
`default_nettype wire

### rtl/multi_channel_interval_timer_top.sv
// Top level of the interval timer bank: timer memory, sequencer and result register.
// Each accepted beat steps through every timer, reading its entry and then evaluating it, and runs
// the catch-up divider for each timer that expires with a nonzero period; it then reads and updates
// the addressed timer and loads the result beat. A new beat is taken only in idle, once the last
// result is loaded; catch-up division, the single memory port and a stalled result beat delay it.
// Reset clears the sequencer, the result valid flag and the entry valid bits, so timers read idle.
`default_nettype none
module multi_channel_interval_timer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [2:0]  timer_index,
    input  wire logic [31:0] elapsed_cycles,
    input  wire logic [31:0] amount,
    input  wire logic [31:0] period_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      expiry_count
);

    mcit_pkg::state_t state_reg, state_next;
    mcit_pkg::entry_t mem [mcit_pkg::TIMER_COUNT];
    mcit_pkg::entry_t rd_data_reg;
    mcit_pkg::entry_t ent;
    mcit_pkg::entry_t wr_data;
    mcit_pkg::div_req_t div_req;
    mcit_pkg::div_rsp_t div_rsp;

    logic [mcit_pkg::TIMER_COUNT-1:0] valid_reg;
    logic        rd_vld_reg;
    logic [mcit_pkg::TIDX_W-1:0] tidx_reg;
    logic [2:0]  op_reg;
    logic [2:0]  idx_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] amount_reg;
    logic [31:0] period_reg;
    logic        out_valid_reg;
    logic [31:0] out_count_reg;

    logic        rd_en;
    logic [mcit_pkg::TIDX_W-1:0] rd_addr;
    logic        wr_en;
    logic [mcit_pkg::TIDX_W-1:0] wr_addr;
    logic        step_done;
    logic        out_load;
    logic [31:0] out_value;
    logic [31:0] idx_wide;
    logic [mcit_pkg::TIDX_W-1:0] idx_addr;
    logic        idx_ok;
    logic [31:0] sum;
    logic        last_timer;

    assign idx_wide = 32'(idx_reg);
    assign idx_addr = idx_wide[mcit_pkg::TIDX_W-1:0];
    assign idx_ok = idx_wide < 32'(mcit_pkg::TIMER_COUNT);
    assign ent = rd_vld_reg ? rd_data_reg : '0;
    assign sum = ent.rem + amount_reg;
    assign last_timer = tidx_reg == mcit_pkg::TIDX_W'(mcit_pkg::TIMER_COUNT - 1);

    mcit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcit_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcit_pkg::ST_READ;
                end
            end
            mcit_pkg::ST_READ:
            begin
                state_next = mcit_pkg::ST_EVAL;
            end
            mcit_pkg::ST_EVAL, mcit_pkg::ST_DIV:
            begin
                if (div_req.start)
                begin
                    state_next = mcit_pkg::ST_DIV;
                end
                else if (step_done)
                begin
                    state_next = last_timer ? mcit_pkg::ST_OPREAD : mcit_pkg::ST_READ;
                end
            end
            mcit_pkg::ST_OPREAD:
            begin
                state_next = mcit_pkg::ST_OPEVAL;
            end
            mcit_pkg::ST_OPEVAL:
            begin
                if (out_load)
                begin
                    state_next = mcit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcit_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_en = 1'b0;
        rd_addr = tidx_reg;
        wr_en = 1'b0;
        wr_addr = tidx_reg;
        wr_data = ent;
        step_done = 1'b0;
        out_load = 1'b0;
        out_value = '0;
        div_req.start = 1'b0;
        div_req.dividend = elapsed_reg - ent.rem;
        div_req.divisor = ent.per;
        case (state_reg)
            mcit_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            mcit_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            mcit_pkg::ST_EVAL:
            begin
                if (!ent.run)
                begin
                    step_done = 1'b1;
                end
                else if (ent.rem > elapsed_reg)
                begin
                    wr_en = 1'b1;
                    wr_data.rem = ent.rem - elapsed_reg;
                    step_done = 1'b1;
                end
                else if (ent.per == '0)
                begin
                    wr_en = 1'b1;
                    wr_data.cnt = ent.cnt + 32'd1;
                    wr_data.run = 1'b0;
                    wr_data.rem = '0;
                    step_done = 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                end
            end
            mcit_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    wr_en = 1'b1;
                    wr_data.cnt = ent.cnt + div_rsp.quot + 32'd1;
                    wr_data.rem = ent.per - div_rsp.rmd;
                    step_done = 1'b1;
                end
            end
            mcit_pkg::ST_OPREAD:
            begin
                rd_en = 1'b1;
                rd_addr = idx_addr;
            end
            mcit_pkg::ST_OPEVAL:
            begin
                wr_addr = idx_addr;
                if (!(out_valid_reg && out_stall))
                begin
                    out_load = 1'b1;
                    wr_en = idx_ok;
                    case (op_reg)
                        mcit_pkg::OP_ARM:
                        begin
                            wr_data.rem = amount_reg;
                            wr_data.per = period_reg;
                            wr_data.cnt = '0;
                            wr_data.run = 1'b1;
                        end
                        mcit_pkg::OP_ADD:
                        begin
                            wr_data.rem = (sum < amount_reg) ? 32'hFFFF_FFFF : sum;
                        end
                        mcit_pkg::OP_PERIOD:
                        begin
                            wr_data.per = amount_reg;
                        end
                        mcit_pkg::OP_READ:
                        begin
                            wr_data.cnt = '0;
                            out_value = idx_ok ? ent.cnt : '0;
                        end
                        mcit_pkg::OP_ADDEXP:
                        begin
                            wr_data.cnt = ent.cnt + amount_reg;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcit_pkg::ST_IDLE;
            valid_reg <= '0;
            rd_vld_reg <= 1'b0;
            tidx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (state_reg == mcit_pkg::ST_IDLE)
            begin
                tidx_reg <= '0;
            end
            else if (step_done && !last_timer)
            begin
                tidx_reg <= tidx_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg <= operation;
            idx_reg <= timer_index;
            elapsed_reg <= elapsed_cycles;
            amount_reg <= amount;
            period_reg <= period_value;
        end
        if (out_load)
        begin
            out_count_reg <= out_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign expiry_count = out_count_reg;

`ifndef SYNTH
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == mcit_pkg::ST_IDLE)
        else $error("input taken outside idle");
    a_div_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> state_reg == mcit_pkg::ST_EVAL)
        else $error("divider started outside evaluation");
    a_out_from_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == mcit_pkg::ST_OPEVAL && !(out_valid_reg && out_stall))
        else $error("result loaded over a pending beat");
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("memory read and write in one cycle");
`endif

endmodule
`default_nettype wire
